FILE: rtl/klq_pkg.sv
// Shared types and constants for the KeeLoq-style cipher engine.
package klq_pkg;

  localparam int KEY_W       = 64;
  localparam int BLOCK_W     = 32;
  localparam int ROUND_W     = 10;
  localparam int KEY_IDX_W   = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [31:0]        NLF_TABLE    = 32'h3A5C742E;
  localparam logic [KEY_W-1:0]   KEY_RESET    = 64'h3030424F46465453;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 10'd144;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 2'd1;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic decrypt;
    logic key_bit;
  } klq_round_ctl_t;

endpackage

FILE: rtl/klq_round.sv
// One NLFSR round, forward or inverse, shared by every round of a block.
module klq_round (
  input  logic [klq_pkg::BLOCK_W-1:0] state_in,
  input  klq_pkg::klq_round_ctl_t     ctl,
  output logic [klq_pkg::BLOCK_W-1:0] state_out
);

  logic [4:0] nlf_idx;
  logic       fb;

  always_comb begin
    if (ctl.decrypt == klq_pkg::REQ_DECRYPT) begin
      nlf_idx = {state_in[30], state_in[25], state_in[19], state_in[8], state_in[0]};
      fb = klq_pkg::NLF_TABLE[nlf_idx] ^ state_in[15] ^ state_in[31] ^ ctl.key_bit;
      state_out = {state_in[klq_pkg::BLOCK_W-2:0], fb};
    end else begin
      nlf_idx = {state_in[31], state_in[26], state_in[20], state_in[9], state_in[1]};
      fb = klq_pkg::NLF_TABLE[nlf_idx] ^ state_in[0] ^ state_in[16] ^ ctl.key_bit;
      state_out = {fb, state_in[klq_pkg::BLOCK_W-1:1]};
    end
  end

endmodule

FILE: rtl/klq_core.sv
// Round sequencer: holds the working block, counts rounds and drives the result register.
module klq_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [klq_pkg::KEY_W-1:0]    cipher_key,
  input  logic [klq_pkg::ROUND_W-1:0]  round_count,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [klq_pkg::BLOCK_W-1:0]  in_block_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [klq_pkg::BLOCK_W-1:0]  out_block_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [klq_pkg::ROUND_W-1:0]  cnt_r, cnt_nxt;
  logic [klq_pkg::KEY_IDX_W-1:0] kidx_r, kidx_nxt;
  logic                         decrypt_r, decrypt_nxt;
  logic [klq_pkg::BLOCK_W-1:0]  work_r, work_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [klq_pkg::BLOCK_W-1:0]  out_block_r, out_block_nxt;
  logic [klq_pkg::BLOCK_W-1:0]  round_out;
  klq_pkg::klq_round_ctl_t      round_ctl;

  assign round_ctl.decrypt = decrypt_r;
  assign round_ctl.key_bit = cipher_key[kidx_r];

  klq_round u_round (
    .state_in  (work_r),
    .ctl       (round_ctl),
    .state_out (round_out)
  );

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_block_out = out_block_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kidx_nxt      = kidx_r;
    decrypt_nxt   = decrypt_r;
    work_nxt      = work_r;
    out_block_nxt = out_block_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          work_nxt    = in_block_in;
          decrypt_nxt = in_req_type;
          cnt_nxt     = round_count;
          // Decryption walks the key downward from the last round's bit.
          kidx_nxt    = (in_req_type == klq_pkg::REQ_DECRYPT) ?
                        (round_count[klq_pkg::KEY_IDX_W-1:0] - 1'b1) : '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r != '0) begin
          work_nxt = round_out;
          cnt_nxt  = cnt_r - 1'b1;
          kidx_nxt = decrypt_r ? (kidx_r - 1'b1) : (kidx_r + 1'b1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_block_nxt = work_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kidx_r      <= kidx_nxt;
    decrypt_r   <= decrypt_nxt;
    work_r      <= work_nxt;
    out_block_r <= out_block_nxt;
  end

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RUN))
    else $error("accepted item did not start the round sequence");

  a_count_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("round counter did not step down by one");

  a_done_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (cnt_r == '0))
    else $error("finished with rounds left over");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result appeared without a finished block");

endmodule

FILE: rtl/keeloq_cipher_engine_top.sv
// Top level of the KeeLoq-style cipher engine: configuration registers and the round sequencer.
// Each item encrypts or decrypts one 32-bit block, one NLFSR round per clock cycle through a
// single shared round unit. The round_count register (144 after reset) sets the number of
// rounds per item. A new item is accepted only while the sequencer is idle, which it becomes
// when the result is loaded into the output register; a finished result waits for out_ready
// before it is loaded if an earlier one is still held there. The block takes a new item while an earlier result
// still waits in the output register. Configuration writes are always accepted and must only be
// made while the block is idle; writes to an index beyond CFG_ROUNDS are ignored.
module keeloq_cipher_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [klq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [klq_pkg::KEY_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [klq_pkg::BLOCK_W-1:0]     in_block_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [klq_pkg::BLOCK_W-1:0]     out_block_out
);

  logic [klq_pkg::KEY_W-1:0]   cipher_key_r;
  logic [klq_pkg::ROUND_W-1:0] round_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r  <= klq_pkg::KEY_RESET;
      round_count_r <= klq_pkg::ROUNDS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        klq_pkg::CFG_KEY:    cipher_key_r  <= cfg_data;
        klq_pkg::CFG_ROUNDS: round_count_r <= cfg_data[klq_pkg::ROUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  klq_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cipher_key    (cipher_key_r),
    .round_count   (round_count_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_block_out (out_block_out)
  );

endmodule
